// File: rtl/sfd_pkg.sv
// Shared types and constants for the serial frame deframer.
// Parser phases, header bytes, result kinds and the result record.
// No dependencies.
package sfd_pkg;

  // Frame header bytes and register reset value
  localparam logic [7:0] HDR0          = 8'h0D;
  localparam logic [7:0] HDR1          = 8'h0A;
  localparam logic [7:0] HDR2          = 8'h7E;
  localparam logic [7:0] MAX_LEN_RESET = 8'd80;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_EOF     = 1'b1;

  // Parser phases
  typedef enum logic [2:0] {
    PH_H0   = 3'd0,
    PH_H1   = 3'd1,
    PH_H2   = 3'd2,
    PH_TYPE = 3'd3,
    PH_LEN  = 3'd4,
    PH_DATA = 3'd5,
    PH_CHK  = 3'd6
  } phase_e;

  // One result item
  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic [7:0] frame_type;
    logic [7:0] frame_length;
    logic       checksum_ok;
    logic [7:0] computed_sum;
  } res_t;

endpackage

// File: rtl/sfd_parser.sv
// Front end of the deframer: header hunt, type/length capture, payload count
// and running checksum. Emits one result record per payload or checksum byte.
// Depends on sfd_pkg.
module sfd_parser import sfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  // byte input
  input  logic       in_valid_i,
  input  logic       q_full_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  // result push into the queue
  output logic       push_o,
  output res_t       res_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] type_q, type_d;
  logic [7:0] len_q, len_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] max_len_q;
  logic       accept;
  logic       emit;
  logic [7:0] sum_add;
  logic [7:0] cnt_inc;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign sum_add    = sum_q + rx_byte_i;
  assign cnt_inc    = cnt_q + 8'd1;

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      unique case (phase_q)
        PH_H1:   phase_d = (rx_byte_i == HDR1) ? PH_H2 : PH_H0;
        PH_H2:   phase_d = (rx_byte_i == HDR2) ? PH_TYPE : PH_H0;
        PH_TYPE: phase_d = PH_LEN;
        PH_LEN: begin
          if (rx_byte_i > max_len_q) begin
            phase_d = PH_H0;
          end else begin
            phase_d = (rx_byte_i == 8'd0) ? PH_CHK : PH_DATA;
          end
        end
        PH_DATA: phase_d = (cnt_inc >= len_q) ? PH_CHK : PH_DATA;
        PH_CHK:  phase_d = PH_H0;
        default: phase_d = (rx_byte_i == HDR0) ? PH_H1 : PH_H0;
      endcase
    end
  end

  // Frame context and outputs
  always_comb begin
    sum_d = sum_q;
    type_d = type_q;
    len_d = len_q;
    cnt_d = cnt_q;
    emit = 1'b0;
    res_o = '0;
    res_o.frame_type = type_q;
    res_o.frame_length = len_q;
    unique case (phase_q)
      PH_H1:   if (rx_byte_i == HDR1) sum_d = sum_add;
      PH_H2:   if (rx_byte_i == HDR2) sum_d = sum_add;
      PH_TYPE: begin
        type_d = rx_byte_i;
        sum_d  = sum_add;
      end
      PH_LEN: begin
        if (rx_byte_i <= max_len_q) begin
          len_d = rx_byte_i;
          cnt_d = 8'd0;
          sum_d = sum_add;
        end
      end
      PH_DATA: begin
        sum_d = sum_add;
        cnt_d = cnt_inc;
        emit  = 1'b1;
        res_o.kind = KIND_PAYLOAD;
        res_o.payload_byte = rx_byte_i;
        res_o.byte_index = cnt_q;
        res_o.computed_sum = sum_add;
      end
      PH_CHK: begin
        emit = 1'b1;
        res_o.kind = KIND_EOF;
        res_o.checksum_ok = (rx_byte_i == sum_q);
        res_o.computed_sum = sum_q;
      end
      default: if (rx_byte_i == HDR0) sum_d = HDR0;
    endcase
  end

  assign push_o = accept && emit;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_H0;
      sum_q   <= '0;
      type_q  <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      if (accept) begin
        sum_q  <= sum_d;
        type_q <= type_d;
        len_q  <= len_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  // Max length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_data_i;
    end
  end

endmodule

// File: rtl/sfd_fifo.sv
// Short result queue between the parser and the output channel.
// Register-based ring buffer holding result records.
// Depends on sfd_pkg.
module sfd_fifo import sfd_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  res_t wr_data_i,
  output logic full_o,
  output logic rd_valid_o,
  input  logic rd_en_i,
  output res_t rd_data_o
);

  localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

  res_t            mem_q [Depth];
  logic [IdxW-1:0] wr_ptr_q, wr_ptr_d;
  logic [IdxW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr;
  logic            do_rd;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_en_i && !full_o;
  assign do_rd      = rd_en_i && rd_valid_o;

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
    if (do_rd) rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
    if (do_wr && !do_rd) cnt_d = cnt_q + 1'b1;
    else if (do_rd && !do_wr) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

// File: rtl/serial_frame_deframer.sv
// Serial frame deframer: finds 0D 0A 7E headers in a byte stream and
// passes out payload bytes plus an end-of-frame checksum verdict.
// Usage:
//   s_axis carries one received byte per item. m_axis carries results:
//   tuser = kind (0 payload byte, 1 end of frame), tdata = frame fields.
//   cfg writes the maximum payload length (reset 80); frames declaring a
//   longer payload are dropped. Write it only while the block is idle.
// Timing:
//   One byte is accepted per cycle unless the result queue is full; each payload
//   or checksum byte queues one result for m_axis; header, type and length bytes give none.
//   The rate is set by the parser's registered sum and count update.
// Stall / reset:
//   Results wait in a FifoDepth-entry queue; s_axis_tready drops only when
//   it is full, so a stalled receiver backs up into the input after
//   FifoDepth results. Reset empties the queue and restarts the header hunt.
// Depends on sfd_pkg, sfd_parser, sfd_fifo.
module serial_frame_deframer import sfd_pkg::*; #(
  parameter int FifoDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,     // max_length
  // byte input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [7:0] payload_byte, [15:8] byte_index,
                                      // [23:16] frame_type, [31:24] frame_length,
                                      // [32] checksum_ok, [40:33] computed_sum
  output logic        m_axis_tuser    // [0] kind
);

  logic q_full;
  logic push;
  res_t push_res;
  res_t out_res;

  assign cfg_ready_o = 1'b1;

  // Front: parse and classify bytes
  sfd_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .q_full_i   (q_full),
    .in_ready_o (s_axis_tready),
    .rx_byte_i  (s_axis_tdata),
    .push_o     (push),
    .res_o      (push_res)
  );

  // Back: result queue feeding the output channel
  sfd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (push),
    .wr_data_i  (push_res),
    .full_o     (q_full),
    .rd_valid_o (m_axis_tvalid),
    .rd_en_i    (m_axis_tready),
    .rd_data_o  (out_res)
  );

  // Output packing
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {7'd0, out_res.computed_sum, out_res.checksum_ok,
                         out_res.frame_length, out_res.frame_type,
                         out_res.byte_index, out_res.payload_byte};

endmodule

// File: dv/testbench.sv
// Self-checking testbench for serial_frame_deframer.
// Drives a directed frame table, then random frames under several max_length
// settings, with random gaps on both streams. Depends on sfd_pkg and the RTL.
module testbench;
  import sfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned NUM_ROWS    = 24;
  localparam int unsigned PHASE_ITEMS = 306;

  // One directed row: input byte, plus the result where it is typed in
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    res_t       res;
  } frame_row_t;

  // Zero-length frame with good checksum, two-byte frame with bad checksum,
  // header broken at its third byte, length above the reset maximum.
  localparam frame_row_t FRAME_ROWS [NUM_ROWS] = '{
    '{8'h0D, 1'b0, '0},
    '{8'h0A, 1'b0, '0},
    '{8'h7E, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h95, 1'b1, '{KIND_EOF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h95}},
    '{8'h0D, 1'b0, '0},
    '{8'h0A, 1'b0, '0},
    '{8'h7E, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h02, 1'b0, '0},
    '{8'hFF, 1'b1, '{KIND_PAYLOAD, 8'hFF, 8'h00, 8'hFF, 8'h02, 1'b0, 8'h95}},
    '{8'h00, 1'b1, '{KIND_PAYLOAD, 8'h00, 8'h01, 8'hFF, 8'h02, 1'b0, 8'h95}},
    '{8'h00, 1'b1, '{KIND_EOF, 8'h00, 8'h00, 8'hFF, 8'h02, 1'b0, 8'h95}},
    '{8'h0D, 1'b0, '0},
    '{8'h0A, 1'b0, '0},
    '{8'h0D, 1'b0, '0},
    '{8'h0A, 1'b0, '0},
    '{8'h7E, 1'b0, '0},
    '{8'h0D, 1'b0, '0},
    '{8'h0A, 1'b0, '0},
    '{8'h7E, 1'b0, '0},
    '{8'h05, 1'b0, '0},
    '{8'h51, 1'b0, '0}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i    = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;           // [7:0] payload_byte, [15:8] byte_index,
                                       // [23:16] frame_type, [31:24] frame_length,
                                       // [32] checksum_ok, [40:33] computed_sum
  logic        m_axis_tuser;           // [0] kind

  serial_frame_deframer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Deframer state as predicted by the testbench
  phase_e      hunt_phase = PH_H0;
  logic [7:0]  frame_sum  = 8'h00;
  logic [7:0]  cur_type   = 8'h00;
  logic [7:0]  cur_len    = 8'h00;
  logic [7:0]  pay_count  = 8'h00;
  logic [7:0]  len_limit  = MAX_LEN_RESET;

  res_t        pending_results [$];
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  bit          tx_gaps_on = 1'b1;
  bit          rx_stall_on = 1'b1;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Advance the frame parser by one byte; returns 1 when it yields a result
  function automatic bit deframe_byte(input logic [7:0] b, output res_t r);
    r = '0;
    r.frame_type = cur_type;
    r.frame_length = cur_len;
    case (hunt_phase)
      PH_H1: begin
        if (b == HDR1) begin
          frame_sum += b;
          hunt_phase = PH_H2;
        end else begin
          hunt_phase = PH_H0;
        end
        return 1'b0;
      end
      PH_H2: begin
        if (b == HDR2) begin
          frame_sum += b;
          hunt_phase = PH_TYPE;
        end else begin
          hunt_phase = PH_H0;
        end
        return 1'b0;
      end
      PH_TYPE: begin
        cur_type = b;
        frame_sum += b;
        hunt_phase = PH_LEN;
        return 1'b0;
      end
      PH_LEN: begin
        if (b > len_limit) begin
          hunt_phase = PH_H0;
          return 1'b0;
        end
        cur_len = b;
        pay_count = 8'h00;
        frame_sum += b;
        hunt_phase = (b == 8'h00) ? PH_CHK : PH_DATA;
        return 1'b0;
      end
      PH_DATA: begin
        r.kind = KIND_PAYLOAD;
        r.payload_byte = b;
        r.byte_index = pay_count;
        frame_sum += b;
        pay_count += 8'h01;
        if (pay_count >= cur_len) hunt_phase = PH_CHK;
        r.computed_sum = frame_sum;
        return 1'b1;
      end
      PH_CHK: begin
        hunt_phase = PH_H0;
        r.kind = KIND_EOF;
        r.checksum_ok = (b == frame_sum);
        r.computed_sum = frame_sum;
        return 1'b1;
      end
      default: begin
        if (b == HDR0) begin
          frame_sum = HDR0;
          hunt_phase = PH_H1;
        end else begin
          hunt_phase = PH_H0;
        end
        return 1'b0;
      end
    endcase
  endfunction

  // Send one byte, then queue what it should produce (typed row value if given)
  task automatic push_byte(input logic [7:0] b, input bit typed, input res_t typed_res);
    int unsigned gap;
    res_t        r;
    if ($urandom_range(0, 49) == 0) tx_gaps_on = !tx_gaps_on;
    gap = tx_gaps_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
    if (deframe_byte(b, r)) pending_results.push_back(typed ? typed_res : r);
  endtask

  // Stop sending and wait until every queued result has come out
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_max_length(input logic [7:0] v);
    wait_results_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    len_limit = v;
  endtask

  // Noise leans toward header bytes so that false starts are common
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 5))
      0:       return HDR0;
      1:       return HDR1;
      2:       return HDR2;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly well-formed frames; some noise, cut headers and oversize lengths
  task automatic send_random_frame();
    int unsigned pick;
    int unsigned n;
    logic [7:0]  ftype;
    logic [7:0]  flen;
    logic [7:0]  sum;
    logic [7:0]  b;
    bit          oversize;
    pick = $urandom_range(0, 99);
    oversize = 1'b0;
    if (pick < 12) begin
      n = $urandom_range(1, 6);
      repeat (n) push_byte(noise_byte(), 1'b0, '0);
    end else if (pick < 20) begin
      push_byte(HDR0, 1'b0, '0);
      if ($urandom_range(0, 1) == 0) push_byte(HDR1, 1'b0, '0);
      push_byte(noise_byte(), 1'b0, '0);
    end else begin
      if (pick < 26 && len_limit != 8'hFF) begin
        flen = 8'($urandom_range(len_limit + 1, 255));
        oversize = 1'b1;
      end else if (pick < 30) begin
        flen = 8'($urandom_range(0, len_limit));
      end else begin
        flen = 8'($urandom_range(0, (len_limit < 10) ? len_limit : 10));
      end
      ftype = 8'($urandom_range(0, 255));
      sum = HDR0 + HDR1 + HDR2 + ftype + flen;
      push_byte(HDR0, 1'b0, '0);
      push_byte(HDR1, 1'b0, '0);
      push_byte(HDR2, 1'b0, '0);
      push_byte(ftype, 1'b0, '0);
      push_byte(flen, 1'b0, '0);
      if (!oversize) begin
        for (int i = 0; i < flen; i++) begin
          b = 8'($urandom_range(0, 255));
          sum += b;
          push_byte(b, 1'b0, '0);
        end
        // good checksum most of the time, else one flipped somewhere
        if ($urandom_range(0, 9) < 7) push_byte(sum, 1'b0, '0);
        else push_byte(sum ^ 8'($urandom_range(1, 255)), 1'b0, '0);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input res_t want, input res_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s) at %0t", what, $realtime);
      $display("  expected kind=%0d byte=%02h idx=%0d type=%02h len=%0d ok=%0d sum=%02h",
               want.kind, want.payload_byte, want.byte_index, want.frame_type,
               want.frame_length, want.checksum_ok, want.computed_sum);
      $display("  actual   kind=%0d byte=%02h idx=%0d type=%02h len=%0d ok=%0d sum=%02h",
               got.kind, got.payload_byte, got.byte_index, got.frame_type,
               got.frame_length, got.checksum_ok, got.computed_sum);
    end
  endtask

  // Result side: random stalls, compare each accepted item with the oldest one queued
  initial begin
    int unsigned stall;
    res_t        got;
    res_t        want;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 49) == 0) rx_stall_on = !rx_stall_on;
      stall = rx_stall_on ? $urandom_range(0, 4) : 0;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      got.kind         = m_axis_tuser;
      got.payload_byte = m_axis_tdata[7:0];
      got.byte_index   = m_axis_tdata[15:8];
      got.frame_type   = m_axis_tdata[23:16];
      got.frame_length = m_axis_tdata[31:24];
      got.checksum_ok  = m_axis_tdata[32];
      got.computed_sum = m_axis_tdata[40:33];
      if (pending_results.size() == 0) begin
        report_mismatch("no result expected", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
            got.byte_index !== want.byte_index || got.frame_type !== want.frame_type ||
            got.frame_length !== want.frame_length ||
            got.checksum_ok !== want.checksum_ok ||
            got.computed_sum !== want.computed_sum) begin
          report_mismatch("field differs", want, got);
        end
      end
    end
  end

  // Timeout
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Main sequence
  initial begin
    logic [7:0] setting;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames under the reset maximum
    for (int i = 0; i < NUM_ROWS; i++) begin
      push_byte(FRAME_ROWS[i].rx, FRAME_ROWS[i].typed, FRAME_ROWS[i].res);
    end

    // Random frames under each max_length setting, extremes included
    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       setting = 8'hFF;
        1:       setting = 8'h00;
        2:       setting = 8'h01;
        3:       setting = 8'($urandom_range(2, 254));
        default: setting = MAX_LEN_RESET;
      endcase
      write_max_length(setting);
      while (bytes_sent < NUM_ROWS + (p + 1) * PHASE_ITEMS) send_random_frame();
    end

    wait_results_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/sfd_pkg.sv
rtl/sfd_parser.sv
rtl/sfd_fifo.sv
rtl/serial_frame_deframer.sv
dv/testbench.sv
